>>> hdl/bff_pkg.sv
// Shared constants and types for the band-pass FIR filter unit.
// Used by bff_mac and bandpass_fir_filter_unit; depends on nothing.
`default_nettype none

package bff_pkg;

    localparam int TAPS_DEF        = 29;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 18;
    localparam int ACC_BITS        = 40;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } bff_mac_ctl_t;

    typedef struct packed {
        logic done;
        logic clip;
    } bff_mac_res_t;

endpackage

`default_nettype wire

>>> hdl/bff_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
// Standalone; instantiated by bandpass_fir_filter_unit for taps and sample history.
`default_nettype none

module bff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 29,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bff_mac.sv
// Pipelined multiply-accumulate with rounding and saturation for the FIR unit.
// Depends on bff_pkg for the accumulator width and control structs.
`default_nettype none

module bff_mac #(
    parameter int SAMPLE_BITS = bff_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bff_pkg::COEF_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bff_pkg::bff_mac_ctl_t         ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
    input  wire logic signed [COEF_BITS-1:0]   coef_i,
    output bff_pkg::bff_mac_res_t              res,
    output logic signed [SAMPLE_BITS-1:0]      sample_o
);

    localparam int ACC      = bff_pkg::ACC_BITS;
    localparam int PW       = SAMPLE_BITS + COEF_BITS;
    localparam int EW       = (PW > ACC) ? PW : ACC;
    localparam int CF       = COEF_BITS - 3;
    localparam int SUM_BITS = ACC + 1;
    localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(64'd1 << (CF - 1));
    localparam logic signed [SUM_BITS-1:0] HI   =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] LO   = -HI - SUM_BITS'(1);

    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          prod_next;
    bff_pkg::bff_mac_ctl_t         pctl_reg;
    logic signed [EW-1:0]          prod_ext;
    logic signed [ACC-1:0]         prod_acc;
    logic signed [ACC-1:0]         acc_reg;
    logic                          last_reg;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SUM_BITS-1:0]    shifted;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic                          clip_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          clip_reg;
    logic                          done_reg;

    assign prod_next = sample_i * coef_i;
    assign prod_ext  = EW'(prod_reg);
    assign prod_acc  = prod_ext[ACC-1:0];

    assign sum     = SUM_BITS'(acc_reg) + HALF;
    assign shifted = sum >>> CF;

    always_comb begin
        priority if (shifted > HI) begin
            sample_next = SAMPLE_BITS'(HI);
            clip_next   = 1'b1;
        end else if (shifted < LO) begin
            sample_next = SAMPLE_BITS'(LO);
            clip_next   = 1'b1;
        end else begin
            sample_next = shifted[SAMPLE_BITS-1:0];
            clip_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pctl_reg <= '0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            pctl_reg <= ctl;
            last_reg <= pctl_reg.vld & pctl_reg.last;
            done_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (pctl_reg.vld) begin
            acc_reg <= pctl_reg.first ? prod_acc : acc_reg + prod_acc;
        end
        if (last_reg) begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
        end
    end

    assign res.done = done_reg;
    assign res.clip = clip_reg;
    assign sample_o = sample_reg;

endmodule

`default_nettype wire

>>> hdl/bandpass_fir_filter_unit.sv
// Top level of the band-pass FIR filter unit: sequencer, tap and history memories.
// Depends on bff_pkg, bff_ram and bff_mac.
//
// Usage: words arrive on the s_ channel. A word with s_cmd high writes one
// coefficient at s_tap_index while the unit stays idle; indexes of TAPS and
// above are dropped. A word with s_cmd low writes one sample into the history
// ring. Once TAPS earlier samples are held, the sample starts a convolution
// that walks one tap per cycle through both memories and one shared
// multiplier; the result passes the memory read, product, accumulator and
// rounding registers to reach the m_ channel. Samples taken during warm-up
// give no result and leave the unit idle. s_ready is high only between items,
// so the unit takes no new word until a convolution is through; throughput is
// bound by the single read port per memory and the one multiply-accumulate unit.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver still stalls when a new result is ready, the unit
// holds that result and stops taking words until the register frees up.
// Reset clears the warm-up count, the ring position and the per-tap valid
// bits, so every coefficient reads as zero until written; no clearing pass.
`default_nettype none

module bandpass_fir_filter_unit #(
    parameter int TAPS        = bff_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = bff_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bff_pkg::COEF_BITS_DEF,
    localparam int IDX_BITS   = $clog2(TAPS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [IDX_BITS-1:0]           s_tap_index,
    input  wire logic signed [COEF_BITS-1:0]   s_tap_value,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_clipped
);

    localparam int CNT_BITS = $clog2(TAPS + 1);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TAPS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [IDX_BITS-1:0]           pos_reg, pos_next;
    logic [CNT_BITS-1:0]           seen_reg, seen_next;
    logic [IDX_BITS-1:0]           cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]           slot_reg, slot_next;
    logic [TAPS-1:0]               coef_vld_reg, coef_vld_next;
    logic                          coef_rd_vld_reg;
    bff_pkg::bff_mac_ctl_t         rd_ctl_reg, rd_ctl_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic                          m_clip_reg;

    logic                          accept;
    logic                          tap_in_range;
    logic                          coef_we;
    logic                          samp_we;
    logic                          run;
    logic                          out_free;
    logic                          load_out;
    logic [COEF_BITS-1:0]          coef_rdata;
    logic [SAMPLE_BITS-1:0]        samp_rdata;
    logic signed [COEF_BITS-1:0]   coef_q;
    bff_pkg::bff_mac_res_t         mac_res;
    logic signed [SAMPLE_BITS-1:0] mac_sample;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid & s_ready;
    assign tap_in_range = (IDX_BITS + 1)'(s_tap_index) < (IDX_BITS + 1)'(TAPS);
    assign coef_we      = accept & s_cmd & tap_in_range;
    assign samp_we      = accept & ~s_cmd;
    assign run          = (state_reg == ST_RUN);
    assign out_free     = ~m_valid_reg | m_ready;

    bff_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (s_tap_index),
        .wdata (s_tap_value),
        .re    (run),
        .raddr (cnt_reg),
        .rdata (coef_rdata)
    );

    bff_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_samp_ram (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (pos_reg),
        .wdata (s_sample_in),
        .re    (run),
        .raddr (slot_reg),
        .rdata (samp_rdata)
    );

    assign coef_q = coef_rd_vld_reg ? signed'(coef_rdata) : '0;

    bff_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rd_ctl_reg),
        .sample_i (signed'(samp_rdata)),
        .coef_i   (coef_q),
        .res      (mac_res),
        .sample_o (mac_sample)
    );

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        seen_next     = seen_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        coef_vld_next = coef_vld_reg;
        rd_ctl_next   = '0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (coef_we) begin
                    coef_vld_next[s_tap_index] = 1'b1;
                end
                if (samp_we) begin
                    pos_next = (pos_reg == LAST_IDX) ? '0 : pos_reg + IDX_BITS'(1);
                    if (seen_reg == CNT_BITS'(TAPS)) begin
                        state_next = ST_RUN;
                        cnt_next   = '0;
                        slot_next  = pos_reg;
                    end else begin
                        seen_next = seen_reg + CNT_BITS'(1);
                    end
                end
            end
            ST_RUN: begin
                rd_ctl_next.vld   = 1'b1;
                rd_ctl_next.first = (cnt_reg == '0);
                rd_ctl_next.last  = (cnt_reg == LAST_IDX);
                slot_next = (slot_reg == '0) ? LAST_IDX : slot_reg - IDX_BITS'(1);
                cnt_next  = cnt_reg + IDX_BITS'(1);
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_res.done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            seen_reg     <= '0;
            cnt_reg      <= '0;
            slot_reg     <= '0;
            coef_vld_reg <= '0;
            rd_ctl_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            seen_reg     <= seen_next;
            cnt_reg      <= cnt_next;
            slot_reg     <= slot_next;
            coef_vld_reg <= coef_vld_next;
            rd_ctl_reg   <= rd_ctl_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            coef_rd_vld_reg <= coef_vld_reg[cnt_reg];
        end
        if (load_out) begin
            m_sample_reg <= mac_sample;
            m_clip_reg   <= mac_res.clip;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_clipped    = m_clip_reg;

`ifndef SYNTHESIS
    a_taps_stable_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |=> $stable(coef_vld_reg))
        else $error("Coefficient valid bits changed during a convolution.");

    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.done |-> (state_reg == ST_DRAIN))
        else $error("MAC result arrived outside the drain phase.");

    a_hold_has_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> m_valid_reg)
        else $error("Hold state entered with a free output register.");

    a_run_needs_warm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (seen_reg == CNT_BITS'(TAPS)))
        else $error("Convolution started before the history was full.");
`endif

endmodule

`default_nettype wire
